// ----- rtl/core/pefu_pkg.sv -----
// Shared types, constants and text-match tables of the purchase event id filter.
package pefu_pkg;

    localparam int ID_LEN_DEF   = 36;
    localparam int BYTE_W       = 8;
    localparam int EV_KEY_LEN   = 10;
    localparam int ADID_KEY_LEN = 5;
    localparam int PURCHASE_LEN = 8;
    localparam int KEY_CNT_MAX  = 15;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_SEMI  = 8'h3B;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_word;

    // event type key text
    function automatic logic [7:0] ev_key_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h65;
            4'd1:    c = 8'h76;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h74;
            4'd5:    c = 8'h5F;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h79;
            4'd8:    c = 8'h70;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "ad_id"
    function automatic logic [7:0] adid_key_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h61;
            3'd1:    c = 8'h64;
            3'd2:    c = 8'h5F;
            3'd3:    c = 8'h69;
            3'd4:    c = 8'h64;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "purchase"
    function automatic logic [7:0] purchase_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h70;
            3'd1:    c = 8'h75;
            3'd2:    c = 8'h72;
            3'd3:    c = 8'h63;
            3'd4:    c = 8'h68;
            3'd5:    c = 8'h61;
            3'd6:    c = 8'h73;
            default: c = 8'h65;
        endcase
        return c;
    endfunction

endpackage

// ----- rtl/core/pefu_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
module pefu_ram #(
    parameter int WIDTH = pefu_pkg::BYTE_W,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/purchase_event_id_filter_unit.sv -----
// Top level of the purchase event id filter: byte parser, id buffer RAM and id emitter.
//
//   channel | dir | handshake          | word
//   --------+-----+--------------------+------------------------------
//   input   | in  | i_valid / o_ready  | i_data (in_byte, in_last)
//   output  | out | o_valid / i_ready  | o_data (out_byte, out_last)
//
// Input takes one byte per cycle while o_ready is high. A semicolon of a marked
// record sends ID_LEN output words, one per cycle while the consumer keeps i_ready
// high; the RAM read port feeding a four-word output queue sets that pace.
// o_ready drops only while an id is still being sent and the next record is
// already marked; it comes back once the last read of that id is issued.
// Reset is synchronous; the id RAM has no clearing pass (unwritten entries are
// never shown, lengths gate them to zero).
module purchase_event_id_filter_unit #(
    parameter int ID_LEN = pefu_pkg::ID_LEN_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  pefu_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output pefu_pkg::t_out_word o_data
);

    localparam int IDX_W     = (ID_LEN > 1) ? $clog2(ID_LEN) : 1;
    localparam int LEN_W     = $clog2(ID_LEN + 1);
    localparam int VC_MAX    = (ID_LEN > pefu_pkg::PURCHASE_LEN) ? ID_LEN
                                                                 : pefu_pkg::PURCHASE_LEN;
    localparam int VC_W      = $clog2(VC_MAX + 1);
    localparam int ADDR_W    = IDX_W + 2;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    // Three banks of the RAM rotate: one takes the value being typed, one holds
    // the current id, one may be read out by the emitter.
    function automatic logic [1:0] pick_bank(input logic [1:0] a, input logic [1:0] b);
        logic [1:0] s;
        if (a != 2'd0 && b != 2'd0) begin
            s = 2'd0;
        end else if (a != 2'd1 && b != 2'd1) begin
            s = 2'd1;
        end else begin
            s = 2'd2;
        end
        return s;
    endfunction

    // parser state
    logic [3:0]       r_key_count, n_key_count;
    logic             r_key_ev_ok, n_key_ev_ok;
    logic             r_key_ad_ok, n_key_ad_ok;
    logic             r_field_ev, n_field_ev;
    logic             r_field_ad, n_field_ad;
    logic [VC_W-1:0]  r_value_count, n_value_count;
    logic             r_val_pur_ok, n_val_pur_ok;
    logic             r_marked, n_marked;
    logic [1:0]       r_cap_bank, n_cap_bank;
    logic [1:0]       r_id_bank, n_id_bank;
    logic [LEN_W-1:0] r_id_len, n_id_len;

    // emitter state
    logic             r_burst_busy, n_burst_busy;
    logic [1:0]       r_burst_bank, n_burst_bank;
    logic [LEN_W-1:0] r_burst_len, n_burst_len;
    logic [IDX_W-1:0] r_burst_idx, n_burst_idx;
    logic             r_rd_pend;
    logic             r_rd_keep;
    logic             r_rd_last;

    // output queue
    pefu_pkg::t_out_word r_fifo [4];
    logic [1:0]          r_wr_ptr;
    logic [1:0]          r_rd_ptr;
    logic [2:0]          r_count;

    logic             in_acc;
    logic [7:0]       in_b;
    logic             kp_ev_ok, kp_ad_ok;
    logic [3:0]       kp_count;
    logic             vp_pur_ok;
    logic [VC_W-1:0]  vp_count;
    logic             vp_in_range;
    logic [1:0]       free_bank;
    logic             ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic             issue;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;
    logic             push, pop;
    pefu_pkg::t_out_word push_word;

    assign in_acc  = i_valid && o_ready;
    assign in_b    = i_data.in_byte;
    assign o_ready = !(r_burst_busy && r_marked);

    // key and value push results for the incoming byte
    always_comb begin
        kp_ev_ok = r_key_ev_ok && (r_key_count < 4'(pefu_pkg::EV_KEY_LEN))
                   && (in_b == pefu_pkg::ev_key_char(r_key_count));
        kp_ad_ok = r_key_ad_ok && (r_key_count < 4'(pefu_pkg::ADID_KEY_LEN))
                   && (in_b == pefu_pkg::adid_key_char(r_key_count[2:0]));
        kp_count = (r_key_count == 4'(pefu_pkg::KEY_CNT_MAX)) ? r_key_count
                                                              : r_key_count + 4'd1;
        vp_pur_ok = r_val_pur_ok && (r_value_count < VC_W'(pefu_pkg::PURCHASE_LEN))
                    && (in_b == pefu_pkg::purchase_char(r_value_count[2:0]));
        vp_count  = (r_value_count == VC_W'(VC_MAX)) ? r_value_count
                                                     : r_value_count + VC_W'(1);
        vp_in_range = r_value_count < VC_W'(ID_LEN);
        free_bank = pick_bank(r_id_bank, r_burst_busy ? r_burst_bank : r_id_bank);
    end

    assign issue = r_burst_busy && ((r_count + {2'b00, r_rd_pend}) < 3'd4);

    always_comb begin
        n_key_count   = r_key_count;
        n_key_ev_ok   = r_key_ev_ok;
        n_key_ad_ok   = r_key_ad_ok;
        n_field_ev    = r_field_ev;
        n_field_ad    = r_field_ad;
        n_value_count = r_value_count;
        n_val_pur_ok  = r_val_pur_ok;
        n_marked      = r_marked;
        n_cap_bank    = r_cap_bank;
        n_id_bank     = r_id_bank;
        n_id_len      = r_id_len;
        n_burst_busy  = r_burst_busy;
        n_burst_bank  = r_burst_bank;
        n_burst_len   = r_burst_len;
        n_burst_idx   = r_burst_idx;
        ram_we        = 1'b0;

        if (issue) begin
            if (r_burst_idx == IDX_W'(ID_LEN - 1)) begin
                n_burst_busy = 1'b0;
                n_burst_idx  = '0;
            end else begin
                n_burst_idx = r_burst_idx + IDX_W'(1);
            end
        end

        if (in_acc) begin
            unique case (in_b)
                pefu_pkg::CH_COLON: begin
                    n_field_ev    = r_key_ev_ok && (r_key_count == 4'(pefu_pkg::EV_KEY_LEN));
                    n_field_ad    = r_key_ad_ok && (r_key_count == 4'(pefu_pkg::ADID_KEY_LEN));
                    n_value_count = '0;
                    n_val_pur_ok  = 1'b1;
                    n_cap_bank    = free_bank;
                    n_key_ev_ok   = kp_ev_ok;
                    n_key_ad_ok   = kp_ad_ok;
                    n_key_count   = kp_count;
                end
                pefu_pkg::CH_COMMA: begin
                    if (r_field_ev && r_val_pur_ok
                        && r_value_count == VC_W'(pefu_pkg::PURCHASE_LEN)) begin
                        n_marked = 1'b1;
                    end
                    // the id is the captured prefix; the bank keeps it until restarted
                    if (r_field_ad) begin
                        n_id_bank = r_cap_bank;
                        n_id_len  = vp_in_range ? LEN_W'(r_value_count) : LEN_W'(ID_LEN);
                    end
                    ram_we        = vp_in_range;
                    n_val_pur_ok  = vp_pur_ok;
                    n_value_count = vp_count;
                    n_key_count   = '0;
                    n_key_ev_ok   = 1'b1;
                    n_key_ad_ok   = 1'b1;
                end
                pefu_pkg::CH_SEMI: begin
                    if (r_marked) begin
                        n_burst_busy = 1'b1;
                        n_burst_bank = r_id_bank;
                        n_burst_len  = r_id_len;
                        n_burst_idx  = '0;
                    end
                    n_marked      = 1'b0;
                    ram_we        = vp_in_range;
                    n_val_pur_ok  = vp_pur_ok;
                    n_value_count = vp_count;
                    n_key_count   = '0;
                    n_key_ev_ok   = 1'b1;
                    n_key_ad_ok   = 1'b1;
                end
                default: begin
                    n_key_ev_ok   = kp_ev_ok;
                    n_key_ad_ok   = kp_ad_ok;
                    n_key_count   = kp_count;
                    ram_we        = vp_in_range;
                    n_val_pur_ok  = vp_pur_ok;
                    n_value_count = vp_count;
                end
            endcase

            if (i_data.in_last) begin
                n_key_count   = '0;
                n_key_ev_ok   = 1'b1;
                n_key_ad_ok   = 1'b1;
                n_field_ev    = 1'b0;
                n_field_ad    = 1'b0;
                n_value_count = '0;
                n_val_pur_ok  = 1'b1;
                n_marked      = 1'b0;
                n_cap_bank    = free_bank;
                n_id_len      = '0;
            end
        end
    end

    assign ram_waddr = {r_cap_bank, r_value_count[IDX_W-1:0]};
    assign ram_raddr = {r_burst_bank, r_burst_idx};

    pefu_ram #(
        .WIDTH (pefu_pkg::BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (in_b),
        .i_re    (issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign push               = r_rd_pend;
    assign pop                = o_valid && i_ready;
    assign push_word.out_byte = r_rd_keep ? ram_rdata : 8'h00;
    assign push_word.out_last = r_rd_last;
    assign o_valid            = r_count != 3'd0;
    assign o_data             = r_fifo[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count   <= '0;
            r_key_ev_ok   <= 1'b1;
            r_key_ad_ok   <= 1'b1;
            r_field_ev    <= 1'b0;
            r_field_ad    <= 1'b0;
            r_value_count <= '0;
            r_val_pur_ok  <= 1'b1;
            r_marked      <= 1'b0;
            r_cap_bank    <= 2'd0;
            r_id_bank     <= 2'd0;
            r_id_len      <= '0;
            r_burst_busy  <= 1'b0;
            r_burst_idx   <= '0;
            r_rd_pend     <= 1'b0;
            r_wr_ptr      <= 2'd0;
            r_rd_ptr      <= 2'd0;
            r_count       <= 3'd0;
        end else begin
            r_key_count   <= n_key_count;
            r_key_ev_ok   <= n_key_ev_ok;
            r_key_ad_ok   <= n_key_ad_ok;
            r_field_ev    <= n_field_ev;
            r_field_ad    <= n_field_ad;
            r_value_count <= n_value_count;
            r_val_pur_ok  <= n_val_pur_ok;
            r_marked      <= n_marked;
            r_cap_bank    <= n_cap_bank;
            r_id_bank     <= n_id_bank;
            r_id_len      <= n_id_len;
            r_burst_busy  <= n_burst_busy;
            r_burst_idx   <= n_burst_idx;
            r_rd_pend     <= issue;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + {2'b00, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_burst_bank <= n_burst_bank;
        r_burst_len  <= n_burst_len;
        if (issue) begin
            r_rd_keep <= LEN_W'(r_burst_idx) < r_burst_len;
            r_rd_last <= r_burst_idx == IDX_W'(ID_LEN - 1);
        end
        if (push) begin
            r_fifo[r_wr_ptr] <= push_word;
        end
    end

endmodule

// ----- rtl/core/pefu_checker.sv -----
// Port-level checker for the purchase event id filter, bound to its top level.
module pefu_checker #(
    parameter int ID_LEN = pefu_pkg::ID_LEN_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input pefu_pkg::t_in_word  i_data,
    input logic                o_valid,
    input logic                i_ready,
    input pefu_pkg::t_out_word o_data
);

    localparam int POS_W = (ID_LEN > 1) ? $clog2(ID_LEN) : 1;

    // position of the next output word within its id
    logic [POS_W-1:0] r_pos;
    logic             out_acc;

    assign out_acc = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (out_acc) begin
            if (r_pos == POS_W'(ID_LEN - 1)) begin
                r_pos <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    a_last_at_id_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_data.out_last == (r_pos == POS_W'(ID_LEN - 1))))
        else $error("out_last not on the final byte of an id");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("stalled output word changed");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_ready && !o_valid))
        else $error("block not idle after reset");

    a_in_ready_in_reset_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.in_last && !o_valid) |=> o_ready)
        else $error("input stalled right after a message end with no id pending");

endmodule

bind purchase_event_id_filter_unit pefu_checker #(.ID_LEN(ID_LEN)) u_pefu_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

// ----- sim/purchase_event_id_filter_checker.sv -----
// Checker for the purchase event id filter: watches both channels, predicts id words, compares.
module purchase_event_id_filter_checker
    import pefu_pkg::*;
#(
    parameter int ID_LEN = ID_LEN_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_data,
    output int        o_fail_count,
    output int        o_ids_pending
);

    localparam int VALUE_LEN_MAX = (ID_LEN > PURCHASE_LEN) ? ID_LEN : PURCHASE_LEN;
    localparam logic [8*EV_KEY_LEN-1:0]   EVENT_KEY_TEXT = {"event", "_type"};
    localparam logic [8*ADID_KEY_LEN-1:0] ADID_KEY_TEXT  = "ad_id";
    localparam logic [8*PURCHASE_LEN-1:0] PURCHASE_TEXT  = "purchase";

    logic [3:0]  key_len;
    logic        key_event_ok;
    logic        key_adid_ok;
    logic        in_event_field;
    logic        in_adid_field;
    int unsigned value_len;
    logic        value_purchase_ok;
    logic        purchase_seen;
    logic [7:0]  value_buf [ID_LEN];
    logic [7:0]  ad_id [ID_LEN];

    t_out_word   id_words_q[$];
    t_out_word   want;
    int          fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic restart_key();
        key_len      = '0;
        key_event_ok = 1'b1;
        key_adid_ok  = 1'b1;
    endtask

    task automatic restart_value();
        value_len         = 0;
        value_purchase_ok = 1'b1;
        for (int i = 0; i < ID_LEN; i++) value_buf[i] = 8'h00;
    endtask

    task automatic push_key_char(input logic [7:0] b);
        if (key_len >= EV_KEY_LEN) begin
            key_event_ok = 1'b0;
        end else if (b != EVENT_KEY_TEXT[8*(EV_KEY_LEN-1-int'(key_len)) +: 8]) begin
            key_event_ok = 1'b0;
        end
        if (key_len >= ADID_KEY_LEN) begin
            key_adid_ok = 1'b0;
        end else if (b != ADID_KEY_TEXT[8*(ADID_KEY_LEN-1-int'(key_len)) +: 8]) begin
            key_adid_ok = 1'b0;
        end
        if (key_len < KEY_CNT_MAX) key_len = key_len + 4'd1;
    endtask

    task automatic push_value_char(input logic [7:0] b);
        if (value_len >= PURCHASE_LEN) begin
            value_purchase_ok = 1'b0;
        end else if (b != PURCHASE_TEXT[8*(PURCHASE_LEN-1-int'(value_len)) +: 8]) begin
            value_purchase_ok = 1'b0;
        end
        if (value_len < ID_LEN) value_buf[value_len] = b;
        if (value_len < VALUE_LEN_MAX) value_len++;
    endtask

    task automatic clear_parser();
        restart_key();
        restart_value();
        in_event_field = 1'b0;
        in_adid_field  = 1'b0;
        purchase_seen  = 1'b0;
        for (int i = 0; i < ID_LEN; i++) ad_id[i] = 8'h00;
    endtask

    task automatic parse_byte(input t_in_word w);
        logic [7:0] b;
        t_out_word  id_word;
        b = w.in_byte;
        if (b == CH_COLON) begin
            in_event_field = key_event_ok && (key_len == EV_KEY_LEN);
            in_adid_field  = key_adid_ok && (key_len == ADID_KEY_LEN);
            restart_value();
            push_key_char(b);
        end else if (b == CH_COMMA) begin
            if (in_event_field && value_purchase_ok && value_len == PURCHASE_LEN)
                purchase_seen = 1'b1;
            if (in_adid_field) begin
                for (int i = 0; i < ID_LEN; i++)
                    ad_id[i] = (i < value_len) ? value_buf[i] : 8'h00;
            end
            push_value_char(b);
            restart_key();
        end else if (b == CH_SEMI) begin
            if (purchase_seen) begin
                for (int i = 0; i < ID_LEN; i++) begin
                    id_word.out_byte = ad_id[i];
                    id_word.out_last = (i == ID_LEN - 1);
                    id_words_q.insert(id_words_q.size(), id_word);
                end
            end
            purchase_seen = 1'b0;
            push_value_char(b);
            restart_key();
        end else begin
            push_key_char(b);
            push_value_char(b);
        end
        // message end: parser back to reset, current id too; queued id words stay
        if (w.in_last) clear_parser();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            id_words_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (id_words_q.size() == 0) begin
                    $error("unexpected id word: out_byte %02h out_last %0b",
                           i_out_data.out_byte, i_out_data.out_last);
                    fail_count++;
                end else begin
                    want = id_words_q.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h",
                               want.out_byte, i_out_data.out_byte);
                        fail_count++;
                    end
                    if (i_out_data.out_last !== want.out_last) begin
                        $error("out_last: expected %0b, got %0b",
                               want.out_last, i_out_data.out_last);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) parse_byte(i_in_data);
        end
        o_ids_pending <= id_words_q.size();
    end

endmodule

// ----- sim/purchase_event_id_filter_unit_test.sv -----
// Testbench top for the purchase event id filter: clock, reset, record stimulus and verdict.
module purchase_event_id_filter_unit_test;
    import pefu_pkg::*;

    localparam int ID_LEN       = ID_LEN_DEF;
    localparam int RANDOM_BYTES = 410;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_word  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_word o_data;

    int        fail_count;
    int        ids_pending;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        bytes_sent;
    t_in_word  msg_q[$];

    purchase_event_id_filter_unit #(.ID_LEN(ID_LEN)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    purchase_event_id_filter_checker #(.ID_LEN(ID_LEN)) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .o_fail_count  (fail_count),
        .o_ids_pending (ids_pending)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] pick_char(input bit any_byte);
        logic [7:0] c;
        if (any_byte) begin
            c = 8'($urandom_range(255));
        end else begin
            c = 8'($urandom_range(8'h7E, 8'h21));
            if (c == CH_COLON || c == CH_COMMA || c == CH_SEMI) c = 8'h5F;
        end
        return c;
    endfunction

    task automatic queue_byte(input logic [7:0] b);
        t_in_word w;
        w.in_byte = b;
        w.in_last = 1'b0;
        msg_q.insert(msg_q.size(), w);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) queue_byte(s[k]);
    endtask

    task automatic push_random(input int n, input bit any_byte);
        for (int k = 0; k < n; k++) queue_byte(pick_char(any_byte));
    endtask

    // one record of 1..4 fields; mostly well formed, some broken on purpose
    task automatic build_record();
        int nfields;
        int sel;
        nfields = $urandom_range(1, 4);
        for (int f = 0; f < nfields; f++) begin
            sel = $urandom_range(0, 11);
            case (sel)
                0, 1, 2, 3: begin
                    push_text({"event", "_type:"});
                    case ($urandom_range(0, 9))
                        7:       push_text("purchas");
                        8:       push_text("purchasee");
                        9:       push_text("purchasE");
                        default: push_text("purchase");
                    endcase
                    push_text(",");
                end
                4, 5, 6: begin
                    push_text("ad_id:");
                    push_random($urandom_range(0, ID_LEN + 8), $urandom_range(3) == 0);
                    push_text(",");
                end
                7: begin
                    // colon inside the key: second colon kills the match
                    if ($urandom_range(1)) begin
                        push_text({"event", "_type::purchase,"});
                    end else begin
                        push_text("ad_id::zz,");
                    end
                end
                8: begin
                    // delimiter inside a value
                    push_text("ad_id:");
                    push_random($urandom_range(1, 6), 1'b0);
                    if ($urandom_range(1)) begin
                        push_text(",");
                    end else begin
                        push_text(";");
                    end
                    push_random($urandom_range(1, 6), 1'b0);
                    push_text(",");
                end
                9: begin
                    push_random($urandom_range(1, 14), 1'b0);
                    push_text(":");
                    push_random($urandom_range(0, 10), 1'b0);
                    push_text(",");
                end
                default: begin
                    // field not closed by a comma
                    if ($urandom_range(1)) begin
                        push_text({"event", "_type:purchase"});
                    end else begin
                        push_text("ad_id:abc");
                    end
                end
            endcase
        end
        push_text(";");
    endtask

    task automatic send_word(input t_in_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(negedge i_clk); while (!o_ready);
        @(posedge i_clk);
        bytes_sent++;
    endtask

    // sends queued words until the byte budget is used up; the rest is dropped
    task automatic send_message(input int limit);
        while (msg_q.size() != 0 && bytes_sent < limit) send_word(msg_q.pop_front());
        msg_q.delete();
    endtask

    task automatic wait_ids_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (ids_pending != 0);
        @(posedge i_clk);
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_data         <= '0;
        i_ready        <= 1'b0;
        send_idle_pct  = 6;
        recv_stall_pct = 50;
        bytes_sent     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: id holding 00 and FF, purchase record, message end on the semicolon
        push_text("ad_id:");
        queue_byte(8'h00);
        queue_byte(8'hFF);
        push_text({",event", "_type:purchase,;"});
        msg_q[msg_q.size()-1].in_last = 1'b1;
        send_message(RANDOM_BYTES);
        wait_ids_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 6;  recv_stall_pct = 50; end
                1:       begin send_idle_pct = 50; recv_stall_pct = 6;  end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            while (bytes_sent < (phase + 1) * RANDOM_BYTES / 3) begin
                if ($urandom_range(99) < 15) begin
                    push_random($urandom_range(1, 12), $urandom_range(1) == 1);
                    if ($urandom_range(2) == 0) msg_q[msg_q.size()-1].in_last = 1'b1;
                end else begin
                    repeat ($urandom_range(1, 3)) build_record();
                    if ($urandom_range(4) == 0) msg_q[msg_q.size()-1].in_last = 1'b1;
                end
                send_message((phase + 1) * RANDOM_BYTES / 3);
            end
            wait_ids_drained();
        end

        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
